// File: hw/rtl/pbu_pkg.sv
// Pixel blend unit package: blend mode codes, channel count and the
// per-channel stage records shared by the pipeline stages. No dependencies.
`default_nettype none

package pbu_pkg;

   localparam int unsigned NUM_CHAN = 3;   // blue, green, red
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned PROD_W   = 16;  // product plus rounding term always fits 16 bits

   localparam logic [CHAN_W-1:0] ROUND_BIAS = 8'd127;

   typedef enum logic [1:0] {
      MODE_MULTIPLY = 2'd0,
      MODE_SUBTRACT = 2'd1,
      MODE_SCREEN   = 2'd2,
      MODE_OVERLAY  = 2'd3
   } blend_mode_type;

   // operands for the shared multiply path of one channel
   typedef struct packed {
      logic [CHAN_W-1:0] opa;
      logic [CHAN_W-1:0] opb;
      logic              dbl;      // product times two (overlay)
      logic              inv;      // result is 255 minus quotient
      logic              bypass;   // subtract: skip the multiply path
      logic [CHAN_W-1:0] diff;     // clamped difference
   } prep_chan_type;

   // rounded product of one channel, ready for the divide by 255
   typedef struct packed {
      logic [PROD_W-1:0] sum;
      logic              inv;
      logic              bypass;
      logic [CHAN_W-1:0] diff;
   } prod_chan_type;

endpackage

`default_nettype wire

// File: hw/rtl/pbu_prep_stage.sv
// Stage 1 of the pixel blend pipeline: decodes the blend mode per channel
// into multiply operands and flags, and computes the clamped difference.
// Depends on pbu_pkg.
`default_nettype none

module pbu_prep_stage (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   valid_in,
   input  pbu_pkg::blend_mode_type               mode,
   input  wire [pbu_pkg::CHAN_W-1:0]             top_pix    [pbu_pkg::NUM_CHAN],
   input  wire [pbu_pkg::CHAN_W-1:0]             bottom_pix [pbu_pkg::NUM_CHAN],
   output logic                                  valid_out,
   output pbu_pkg::prep_chan_type                prep_out   [pbu_pkg::NUM_CHAN]
);

   logic                   valid_ff;
   pbu_pkg::prep_chan_type prep_ff [pbu_pkg::NUM_CHAN];
   pbu_pkg::prep_chan_type prep_in [pbu_pkg::NUM_CHAN];

   for (genvar ch = 0; ch < pbu_pkg::NUM_CHAN; ch++) begin : g_chan
      always_comb begin
         logic [pbu_pkg::CHAN_W-1:0] t;
         logic [pbu_pkg::CHAN_W-1:0] b;
         t = top_pix[ch];
         b = bottom_pix[ch];
         prep_in[ch].opa    = t;
         prep_in[ch].opb    = b;
         prep_in[ch].dbl    = 1'b0;
         prep_in[ch].inv    = 1'b0;
         prep_in[ch].bypass = 1'b0;
         prep_in[ch].diff   = (t > b) ? (t - b) : '0;
         unique case (mode)
            pbu_pkg::MODE_MULTIPLY: begin
            end
            pbu_pkg::MODE_SUBTRACT: begin
               prep_in[ch].bypass = 1'b1;
            end
            pbu_pkg::MODE_SCREEN: begin
               prep_in[ch].opa = ~t;
               prep_in[ch].opb = ~b;
               prep_in[ch].inv = 1'b1;
            end
            pbu_pkg::MODE_OVERLAY: begin
               // upper half of bottom takes the screen branch; either way
               // the second operand stays below 128, so doubling cannot overflow
               prep_in[ch].dbl = 1'b1;
               if (b[pbu_pkg::CHAN_W-1]) begin
                  prep_in[ch].opa = ~t;
                  prep_in[ch].opb = ~b;
                  prep_in[ch].inv = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      always_ff @(posedge clock) begin
         prep_ff[ch] <= prep_in[ch];
      end

      assign prep_out[ch] = prep_ff[ch];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign valid_out = valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pbu_mult_stage.sv
// Stage 2 of the pixel blend pipeline: 8x8 product per channel, optional
// doubling, plus the rounding bias. Depends on pbu_pkg.
`default_nettype none

module pbu_mult_stage (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       valid_in,
   input  pbu_pkg::prep_chan_type    prep_in  [pbu_pkg::NUM_CHAN],
   output logic                      valid_out,
   output pbu_pkg::prod_chan_type    prod_out [pbu_pkg::NUM_CHAN]
);

   logic                   valid_ff;
   pbu_pkg::prod_chan_type prod_ff [pbu_pkg::NUM_CHAN];
   pbu_pkg::prod_chan_type prod_in [pbu_pkg::NUM_CHAN];

   for (genvar ch = 0; ch < pbu_pkg::NUM_CHAN; ch++) begin : g_chan
      always_comb begin
         logic [pbu_pkg::PROD_W-1:0] prod;
         logic [pbu_pkg::PROD_W-1:0] scaled;
         prod   = pbu_pkg::PROD_W'(prep_in[ch].opa) * pbu_pkg::PROD_W'(prep_in[ch].opb);
         scaled = prep_in[ch].dbl ? {prod[pbu_pkg::PROD_W-2:0], 1'b0} : prod;
         prod_in[ch].sum    = scaled + pbu_pkg::PROD_W'(pbu_pkg::ROUND_BIAS);
         prod_in[ch].inv    = prep_in[ch].inv;
         prod_in[ch].bypass = prep_in[ch].bypass;
         prod_in[ch].diff   = prep_in[ch].diff;
      end

      always_ff @(posedge clock) begin
         prod_ff[ch] <= prod_in[ch];
      end

      assign prod_out[ch] = prod_ff[ch];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign valid_out = valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pbu_norm_stage.sv
// Stage 3 of the pixel blend pipeline: exact divide by 255 per channel,
// inversion for the screen branches and the subtract bypass. Depends on pbu_pkg.
`default_nettype none

module pbu_norm_stage (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           valid_in,
   input  pbu_pkg::prod_chan_type        prod_in [pbu_pkg::NUM_CHAN],
   output logic                          valid_out,
   output logic [pbu_pkg::CHAN_W-1:0]    pix_out [pbu_pkg::NUM_CHAN]
);

   logic                        valid_ff;
   logic [pbu_pkg::CHAN_W-1:0]  pix_ff [pbu_pkg::NUM_CHAN];
   logic [pbu_pkg::CHAN_W-1:0]  pix_in [pbu_pkg::NUM_CHAN];

   for (genvar ch = 0; ch < pbu_pkg::NUM_CHAN; ch++) begin : g_chan
      always_comb begin
         logic [pbu_pkg::PROD_W:0]   acc;
         logic [pbu_pkg::CHAN_W-1:0] quot;
         // floor(x/255) = (x + (x >> 8) + 1) >> 8, exact for x below 65535;
         // x here never exceeds 65152
         acc  = {1'b0, prod_in[ch].sum}
              + (pbu_pkg::PROD_W+1)'(prod_in[ch].sum[pbu_pkg::PROD_W-1:pbu_pkg::CHAN_W])
              + (pbu_pkg::PROD_W+1)'(1);
         quot = acc[pbu_pkg::PROD_W-1:pbu_pkg::CHAN_W];
         if (prod_in[ch].bypass) begin
            pix_in[ch] = prod_in[ch].diff;
         end else if (prod_in[ch].inv) begin
            pix_in[ch] = ~quot;
         end else begin
            pix_in[ch] = quot;
         end
      end

      always_ff @(posedge clock) begin
         pix_ff[ch] <= pix_in[ch];
      end

      assign pix_out[ch] = pix_ff[ch];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign valid_out = valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rgb_pixel_blend_unit.sv
// Pixel blend unit top level: mode register, three pipeline stages.
// Depends on pbu_pkg, pbu_prep_stage, pbu_mult_stage, pbu_norm_stage.
// The valid bit passes the prep, mult and norm stage registers from start to rsp_valid; one pixel accepted every cycle.
// Rate is set by the three-stage multiply / divide-by-255 pipeline; busy stays low.
// Reset (synchronous) clears the pipeline valid bits and sets the mode to multiply.
// The mode is sampled when a request is accepted.
`default_nettype none

module rgb_pixel_blend_unit (
   input  wire         clock,
   input  wire         reset,
   // request
   input  wire         start,
   output logic        busy,
   input  wire  [7:0]  req_top_blue,
   input  wire  [7:0]  req_top_green,
   input  wire  [7:0]  req_top_red,
   input  wire  [7:0]  req_bottom_blue,
   input  wire  [7:0]  req_bottom_green,
   input  wire  [7:0]  req_bottom_red,
   // result
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_blue,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_red,
   // mode register write
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_wdata
);

   pbu_pkg::blend_mode_type     mode_ff;
   logic                        accept;

   logic [pbu_pkg::CHAN_W-1:0]  top_pix    [pbu_pkg::NUM_CHAN];
   logic [pbu_pkg::CHAN_W-1:0]  bottom_pix [pbu_pkg::NUM_CHAN];
   logic [pbu_pkg::CHAN_W-1:0]  pix_out    [pbu_pkg::NUM_CHAN];

   logic                        s1_valid;
   logic                        s2_valid;
   pbu_pkg::prep_chan_type      s1_prep [pbu_pkg::NUM_CHAN];
   pbu_pkg::prod_chan_type      s2_prod [pbu_pkg::NUM_CHAN];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pbu_pkg::MODE_MULTIPLY;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= pbu_pkg::blend_mode_type'(csr_wdata);
      end
   end

   assign top_pix[0]    = req_top_blue;
   assign top_pix[1]    = req_top_green;
   assign top_pix[2]    = req_top_red;
   assign bottom_pix[0] = req_bottom_blue;
   assign bottom_pix[1] = req_bottom_green;
   assign bottom_pix[2] = req_bottom_red;

   pbu_prep_stage u_prep (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (accept),
      .mode       (mode_ff),
      .top_pix    (top_pix),
      .bottom_pix (bottom_pix),
      .valid_out  (s1_valid),
      .prep_out   (s1_prep)
   );

   pbu_mult_stage u_mult (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (s1_valid),
      .prep_in   (s1_prep),
      .valid_out (s2_valid),
      .prod_out  (s2_prod)
   );

   pbu_norm_stage u_norm (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (s2_valid),
      .prod_in   (s2_prod),
      .valid_out (rsp_valid),
      .pix_out   (pix_out)
   );

   assign rsp_out_blue  = pix_out[0];
   assign rsp_out_green = pix_out[1];
   assign rsp_out_red   = pix_out[2];

`ifndef SYNTHESIS
   // every result traces back to an accepted request, through the prep, mult and norm stage registers
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("result without matching request");

   // subtract with bottom at or above top clamps to zero
   a_sub_clamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(mode_ff, 3) == pbu_pkg::MODE_SUBTRACT
       && $past(req_top_blue, 3) <= $past(req_bottom_blue, 3))
      |-> rsp_out_blue == 8'd0)
      else $error("subtract did not clamp");

   // multiply by full-scale bottom returns top unchanged
   a_mul_identity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(mode_ff, 3) == pbu_pkg::MODE_MULTIPLY
       && $past(req_bottom_red, 3) == 8'd255)
      |-> rsp_out_red == $past(req_top_red, 3))
      else $error("multiply by 255 changed the channel");
`endif

endmodule

`default_nettype wire
